@@ design/knn_graph_pruned_expansion_unit_assert.svh @@
// Assertion macros for the kNN graph expansion unit.
// Every macro samples on i_clk and is disabled while i_rst_n is low.
`ifndef KNN_GRAPH_PRUNED_EXPANSION_UNIT_ASSERT_SVH
`define KNN_GRAPH_PRUNED_EXPANSION_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define KGPE_ASSERT_NOW(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);
`define KGPE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define KGPE_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define KGPE_ASSERT_NOW(lbl, cond, msg)
`define KGPE_ASSERT_IMP(lbl, ante, cons, msg)
`define KGPE_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

@@ design/kgpe_pkg.sv @@
`timescale 1ns / 1ps
package kgpe_pkg;
    localparam int NUM_NODES = 4096;
    localparam int MAX_ROW   = 32;
    localparam int MAX_HOPS  = 8;
    localparam int LIST_CAP  = NUM_NODES + MAX_ROW;

    localparam int NODE_AW = $clog2(NUM_NODES);
    localparam int ROW_AW  = $clog2(MAX_ROW);
    localparam int NBR_AW  = NODE_AW + ROW_AW;
    localparam int NBR_W   = 13;
    localparam int RAD_W   = 32;
    localparam int RATIO_W = 16;
    localparam int LIM_W   = RAD_W + RATIO_W;
    localparam int CUR_W   = $clog2(MAX_ROW + 1);
    localparam int HOP_W   = $clog2(MAX_HOPS + 2);
    localparam int LIST_AW = $clog2(LIST_CAP);
    localparam int CNT_W   = $clog2(LIST_CAP + 1);
    localparam int EP_W    = 8;

    localparam int RW_CFG_W  = 6;
    localparam int HOP_CFG_W = 4;

    localparam logic [RW_CFG_W-1:0]  RW_RESET    = RW_CFG_W'(16);
    localparam logic [HOP_CFG_W-1:0] HOPS_RESET  = HOP_CFG_W'(2);
    localparam logic [RATIO_W-1:0]   RATIO_RESET = RATIO_W'(55706);

    typedef enum logic [1:0] {
        OP_WR_NBR = 2'd0,
        OP_WR_RAD = 2'd1,
        OP_START  = 2'd2,
        OP_NEXT   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        CFG_ROW_WIDTH   = 2'd0,
        CFG_HOP_COUNT   = 2'd1,
        CFG_PRUNE_RATIO = 2'd2,
        CFG_NONE        = 2'd3
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DISPATCH,
        ST_CHECK,
        ST_SEED_W,
        ST_U_W,
        ST_URAD_W,
        ST_SLOT,
        ST_V_W,
        ST_V_CHK,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic accept;
        logic wr_nbr;
        logic wr_rad;
        logic start;
        logic clr_step;
        logic rd_seed;
        logic rd_u;
        logic rd_urad;
        logic ld_limit;
        logic rd_slot;
        logic next_u;
        logic rd_vinfo;
        logic take_seed;
        logic take_exp;
        logic emit_none;
        logic load_out;
        logic advance;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic active;
        logic hop_is1;
        logic cur_lt_rw;
        logic exp_lt_end;
        logic v_ok;
        logic v_seen;
        logic v_pruned;
        logic out_free;
        logic ep_wrap;
        logic clr_done;
    } t_status;
endpackage

@@ design/kgpe_ram.sv @@
`timescale 1ns / 1ps
module kgpe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

@@ design/kgpe_ctrl.sv @@
`timescale 1ns / 1ps
module kgpe_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  kgpe_pkg::t_status i_status,
    output kgpe_pkg::t_cmd   o_cmd,
    output logic             o_in_stall
);
    import kgpe_pkg::*;

    `include "knn_graph_pruned_expansion_unit_assert.svh"

    t_state r_state, n_state;
    t_cmd   cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (i_status.clr_done) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_DISPATCH;
            end
            ST_DISPATCH: begin
                case (i_status.op)
                    OP_START: n_state = i_status.ep_wrap ? ST_CLEAR : ST_IDLE;
                    OP_NEXT:  n_state = ST_CHECK;
                    default:  n_state = ST_IDLE;
                endcase
            end
            ST_CHECK: begin
                if (!i_status.active) begin
                    n_state = ST_EMIT;
                end else if (i_status.hop_is1) begin
                    n_state = i_status.cur_lt_rw ? ST_SEED_W : ST_CHECK;
                end else begin
                    n_state = i_status.exp_lt_end ? ST_U_W : ST_CHECK;
                end
            end
            ST_SEED_W:  n_state = i_status.v_ok ? ST_EMIT : ST_CHECK;
            ST_U_W:     n_state = ST_URAD_W;
            ST_URAD_W:  n_state = ST_SLOT;
            ST_SLOT:    n_state = i_status.cur_lt_rw ? ST_V_W : ST_CHECK;
            ST_V_W:     n_state = i_status.v_ok ? ST_V_CHK : ST_SLOT;
            ST_V_CHK: begin
                n_state = (!i_status.v_seen && !i_status.v_pruned) ? ST_EMIT : ST_SLOT;
            end
            ST_EMIT: begin
                if (i_status.out_free) n_state = ST_IDLE;
            end
            default:    n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        case (r_state)
            ST_CLEAR:    cmd.clr_step = 1'b1;
            ST_IDLE:     cmd.accept = i_in_valid;
            ST_DISPATCH: begin
                cmd.wr_nbr = (i_status.op == OP_WR_NBR);
                cmd.wr_rad = (i_status.op == OP_WR_RAD);
                cmd.start  = (i_status.op == OP_START);
            end
            ST_CHECK: begin
                if (!i_status.active) begin
                    cmd.emit_none = 1'b1;
                end else if (i_status.hop_is1) begin
                    cmd.rd_seed = i_status.cur_lt_rw;
                    cmd.advance = !i_status.cur_lt_rw;
                end else begin
                    cmd.rd_u    = i_status.exp_lt_end;
                    cmd.advance = !i_status.exp_lt_end;
                end
            end
            ST_SEED_W:  cmd.take_seed = i_status.v_ok;
            ST_U_W:     cmd.rd_urad = 1'b1;
            ST_URAD_W:  cmd.ld_limit = 1'b1;
            ST_SLOT: begin
                cmd.rd_slot = i_status.cur_lt_rw;
                cmd.next_u  = !i_status.cur_lt_rw;
            end
            ST_V_W:     cmd.rd_vinfo = i_status.v_ok;
            ST_V_CHK:   cmd.take_exp = !i_status.v_seen && !i_status.v_pruned;
            ST_EMIT:    cmd.load_out = i_status.out_free;
            default:    cmd = '0;
        endcase
    end

    assign o_cmd      = cmd;
    assign o_in_stall = (r_state != ST_IDLE);

    `KGPE_ASSERT_NOW(a_one_result, $onehot0({cmd.take_seed, cmd.take_exp, cmd.emit_none}),
        "more than one result source in a cycle")
    `KGPE_ASSERT_NXT(a_take_emits, cmd.take_seed || cmd.take_exp || cmd.emit_none,
        r_state == ST_EMIT, "result prepared but not emitted")
    `KGPE_ASSERT_IMP(a_dispatch_src, r_state == ST_DISPATCH, $past(cmd.accept),
        "dispatch without an accepted transaction")
    `KGPE_ASSERT_NXT(a_load_idle, cmd.load_out, r_state == ST_IDLE,
        "controller not idle after result load")
endmodule

@@ design/kgpe_dpath.sv @@
`timescale 1ns / 1ps
module kgpe_dpath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  kgpe_pkg::t_cmd              i_cmd,
    output kgpe_pkg::t_status           o_status,
    input  logic [1:0]                  i_opcode,
    input  logic [11:0]                 i_node,
    input  logic [4:0]                  i_slot,
    input  logic signed [12:0]          i_neighbor_node,
    input  logic [31:0]                 i_radius_value,
    input  logic                        i_cfg_valid,
    input  logic [1:0]                  i_cfg_index,
    input  logic [15:0]                 i_cfg_data,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_found,
    output logic [11:0]                 o_candidate_node,
    output logic [3:0]                  o_hop_level
);
    import kgpe_pkg::*;

    localparam logic [NBR_W-1:0]   NODE_LIMIT = NBR_W'(NUM_NODES);
    localparam logic [NODE_AW-1:0] LAST_NODE  = NODE_AW'(NUM_NODES - 1);
    localparam logic [CNT_W-1:0]   CAP        = CNT_W'(LIST_CAP);

    // latched transaction
    t_op                  r_op;
    logic [NODE_AW-1:0]   r_node;
    logic [ROW_AW-1:0]    r_slot;
    logic [NBR_W-1:0]     r_nbr;
    logic [RAD_W-1:0]     r_rad;

    // configuration
    logic [RW_CFG_W-1:0]  r_rw;
    logic [HOP_CFG_W-1:0] r_hops;
    logic [RATIO_W-1:0]   r_ratio;

    // traversal state
    logic                 r_active;
    logic [NODE_AW-1:0]   r_query;
    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     r_exp;
    logic [CNT_W-1:0]     r_end;
    logic [CUR_W-1:0]     r_cur;
    logic [HOP_W-1:0]     r_hop;
    logic [NODE_AW-1:0]   r_u;
    logic [NODE_AW-1:0]   r_v;
    logic [LIM_W-1:0]     r_limit;
    logic [EP_W-1:0]      r_epoch;
    logic [NODE_AW-1:0]   r_clr_addr;

    // result and output registers
    logic                 r_res_found;
    logic [NODE_AW-1:0]   r_res_node;
    logic [HOP_W-1:0]     r_res_hop;
    logic                 r_out_valid;
    logic                 r_found;
    logic [11:0]          r_cand;
    logic [3:0]           r_hop_out;

    // memory ports
    logic                 nbr_re;
    logic [NBR_AW-1:0]    nbr_raddr;
    logic [NBR_W-1:0]     nbr_rdata;
    logic                 rad_re;
    logic [NODE_AW-1:0]   rad_raddr;
    logic [RAD_W-1:0]     rad_rdata;
    logic                 vis_we;
    logic [NODE_AW-1:0]   vis_waddr;
    logic [EP_W-1:0]      vis_wdata;
    logic [EP_W-1:0]      vis_rdata;
    logic                 lst_we;
    logic [LIST_AW-1:0]   lst_raddr;
    logic [NODE_AW-1:0]   lst_rdata;

    logic [CUR_W-1:0]     rw_eff;
    logic [HOP_W-1:0]     hops_eff;
    logic [NODE_AW-1:0]   take_node;
    logic                 take;
    logic [HOP_W-1:0]     hop_inc;

    always_comb begin
        if (CUR_W'(r_rw) > CUR_W'(MAX_ROW) || r_rw > RW_CFG_W'(MAX_ROW)) begin
            rw_eff = CUR_W'(MAX_ROW);
        end else begin
            rw_eff = CUR_W'(r_rw);
        end
        if (r_hops == '0) begin
            hops_eff = HOP_W'(1);
        end else if (HOP_W'(r_hops) > HOP_W'(MAX_HOPS)) begin
            hops_eff = HOP_W'(MAX_HOPS);
        end else begin
            hops_eff = HOP_W'(r_hops);
        end
    end

    assign take      = i_cmd.take_seed || i_cmd.take_exp;
    assign take_node = i_cmd.take_seed ? nbr_rdata[NODE_AW-1:0] : r_v;
    assign hop_inc   = r_hop + HOP_W'(1);

    // memories
    assign nbr_re    = i_cmd.rd_seed || i_cmd.rd_slot;
    assign nbr_raddr = i_cmd.rd_seed ? {r_query, r_cur[ROW_AW-1:0]}
                                     : {r_u, r_cur[ROW_AW-1:0]};
    assign rad_re    = i_cmd.rd_urad || i_cmd.rd_vinfo;
    assign rad_raddr = i_cmd.rd_urad ? lst_rdata : nbr_rdata[NODE_AW-1:0];
    assign vis_we    = i_cmd.clr_step || take;
    assign vis_waddr = i_cmd.clr_step ? r_clr_addr : take_node;
    assign vis_wdata = i_cmd.clr_step ? '0 : r_epoch;
    assign lst_we    = take && (r_count < CAP);
    assign lst_raddr = r_exp[LIST_AW-1:0];

    kgpe_ram #(.WIDTH(NBR_W), .DEPTH(NUM_NODES * MAX_ROW)) u_nbr_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_nbr),
        .i_waddr ({r_node, r_slot}),
        .i_wdata (r_nbr),
        .i_re    (nbr_re),
        .i_raddr (nbr_raddr),
        .o_rdata (nbr_rdata)
    );

    kgpe_ram #(.WIDTH(RAD_W), .DEPTH(NUM_NODES)) u_rad_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_rad),
        .i_waddr (r_node),
        .i_wdata (r_rad),
        .i_re    (rad_re),
        .i_raddr (rad_raddr),
        .o_rdata (rad_rdata)
    );

    kgpe_ram #(.WIDTH(EP_W), .DEPTH(NUM_NODES)) u_vis_ram (
        .i_clk   (i_clk),
        .i_we    (vis_we),
        .i_waddr (vis_waddr),
        .i_wdata (vis_wdata),
        .i_re    (i_cmd.rd_vinfo),
        .i_raddr (nbr_rdata[NODE_AW-1:0]),
        .o_rdata (vis_rdata)
    );

    kgpe_ram #(.WIDTH(NODE_AW), .DEPTH(LIST_CAP)) u_lst_ram (
        .i_clk   (i_clk),
        .i_we    (lst_we),
        .i_waddr (r_count[LIST_AW-1:0]),
        .i_wdata (take_node),
        .i_re    (i_cmd.rd_u),
        .i_raddr (lst_raddr),
        .o_rdata (lst_rdata)
    );

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op   <= t_op'(i_opcode);
            r_node <= i_node;
            r_slot <= i_slot;
            r_nbr  <= i_neighbor_node;
            r_rad  <= i_radius_value;
        end
        if (i_cmd.rd_urad) begin
            r_u <= lst_rdata;
        end
        if (i_cmd.ld_limit) begin
            r_limit <= LIM_W'(r_ratio) * LIM_W'(rad_rdata);
        end
        if (i_cmd.rd_vinfo) begin
            r_v <= nbr_rdata[NODE_AW-1:0];
        end
        if (take) begin
            r_res_found <= 1'b1;
            r_res_node  <= take_node;
            r_res_hop   <= r_hop;
        end else if (i_cmd.emit_none) begin
            r_res_found <= 1'b0;
            r_res_node  <= '0;
            r_res_hop   <= '0;
        end
        if (i_cmd.load_out) begin
            r_found   <= r_res_found;
            r_cand    <= 12'(r_res_node);
            r_hop_out <= 4'(r_res_hop);
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rw        <= RW_RESET;
            r_hops      <= HOPS_RESET;
            r_ratio     <= RATIO_RESET;
            r_active    <= 1'b0;
            r_query     <= '0;
            r_count     <= '0;
            r_exp       <= '0;
            r_end       <= '0;
            r_cur       <= CUR_W'(1);
            r_hop       <= '0;
            r_epoch     <= EP_W'(1);
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_ROW_WIDTH:   r_rw    <= i_cfg_data[RW_CFG_W-1:0];
                    CFG_HOP_COUNT:   r_hops  <= i_cfg_data[HOP_CFG_W-1:0];
                    CFG_PRUNE_RATIO: r_ratio <= i_cfg_data;
                    default:         ;
                endcase
            end
            if (i_cmd.clr_step) begin
                r_clr_addr <= r_clr_addr + NODE_AW'(1);
            end
            if (i_cmd.start) begin
                r_active <= 1'b1;
                r_query  <= r_node;
                r_count  <= '0;
                r_exp    <= '0;
                r_end    <= '0;
                r_cur    <= CUR_W'(1);
                r_hop    <= HOP_W'(1);
                if (r_epoch == '1) begin
                    r_epoch    <= EP_W'(1);
                    r_clr_addr <= '0;
                end else begin
                    r_epoch <= r_epoch + EP_W'(1);
                end
            end
            if (i_cmd.rd_seed || i_cmd.rd_slot) begin
                r_cur <= r_cur + CUR_W'(1);
            end
            if (i_cmd.next_u) begin
                r_exp <= r_exp + CNT_W'(1);
                r_cur <= CUR_W'(1);
            end
            if (lst_we) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (i_cmd.advance) begin
                r_exp <= r_end;
                r_end <= r_count;
                r_cur <= CUR_W'(1);
                r_hop <= hop_inc;
                if (hop_inc > hops_eff || r_end >= r_count) begin
                    r_active <= 1'b0;
                end
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_status.op         = r_op;
        o_status.active     = r_active;
        o_status.hop_is1    = (r_hop == HOP_W'(1));
        o_status.cur_lt_rw  = (r_cur < rw_eff);
        o_status.exp_lt_end = (r_exp < r_end) && (r_exp < CAP);
        o_status.v_ok       = !nbr_rdata[NBR_W-1] && (nbr_rdata < NODE_LIMIT);
        o_status.v_seen     = (vis_rdata == r_epoch);
        o_status.v_pruned   = ({rad_rdata, {RATIO_W{1'b0}}} < r_limit);
        o_status.out_free   = !r_out_valid || !i_out_stall;
        o_status.ep_wrap    = (r_epoch == '1);
        o_status.clr_done   = (r_clr_addr == LAST_NODE);
    end

    assign o_out_valid      = r_out_valid;
    assign o_found          = r_found;
    assign o_candidate_node = r_cand;
    assign o_hop_level      = r_hop_out;
endmodule

@@ design/knn_graph_pruned_expansion_unit.sv @@
`timescale 1ns / 1ps
// Throughput: one transaction at a time, set by the table reads of the scan sequencer,
//   each table having one read port.
// Reset (synchronous, active low): visited-tag clear of all 4096 entries, no input taken;
//   the same clear reruns on a start when the 8-bit query epoch wraps.
module knn_graph_pruned_expansion_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input item channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_opcode,
    input  logic [11:0]        i_node,
    input  logic [4:0]         i_slot,
    input  logic signed [12:0] i_neighbor_node,
    input  logic [31:0]        i_radius_value,
    // configuration write channel
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_found,
    output logic [11:0]        o_candidate_node,
    output logic [3:0]         o_hop_level
);
    import kgpe_pkg::*;

    // Controller sequences the BFS scan; datapath holds the neighbor, radius,
    // visited-tag and candidate-list RAMs plus all pointers.
    t_cmd    cmd;
    t_status status;

    // Config is always writable; the contract keeps writes to idle periods.
    assign o_cfg_ready = 1'b1;

    kgpe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    // Visited marks use epoch tags: a node is visited when its tag matches
    // the current query epoch, so a start needs no clear in the common case.
    kgpe_dpath u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_opcode         (i_opcode),
        .i_node           (i_node),
        .i_slot           (i_slot),
        .i_neighbor_node  (i_neighbor_node),
        .i_radius_value   (i_radius_value),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_found          (o_found),
        .o_candidate_node (o_candidate_node),
        .o_hop_level      (o_hop_level)
    );
endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
    import kgpe_pkg::*;

    // ---------------------------------------------------------------
    // Clock, reset and DUT pins
    // ---------------------------------------------------------------
    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic [1:0]         i_opcode = '0;
    logic [11:0]        i_node = '0;
    logic [4:0]         i_slot = '0;
    logic signed [12:0] i_neighbor_node = '0;
    logic [31:0]        i_radius_value = '0;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [1:0]         i_cfg_index = '0;
    logic [15:0]        i_cfg_data = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic               o_found;
    logic [11:0]        o_candidate_node;
    logic [3:0]         o_hop_level;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    knn_graph_pruned_expansion_unit u_dut (.*);

    // One candidate answer of a next transaction
    typedef struct packed {
        logic        found;
        logic [11:0] node;
        logic [3:0]  hop;
    } t_cand;

    localparam int POOL_SZ   = 16;
    localparam int WDOG_MAX  = 30000;   // covers full visited-tag clears plus long hold-off
    localparam int QUIET_CYC = 64;      // lets a table write/start finish before a cfg write

    // ---------------------------------------------------------------
    // Graph mirror: tables, registers and BFS walk state
    // ---------------------------------------------------------------
    logic signed [12:0] nbr_tbl [NUM_NODES*MAX_ROW];
    logic [31:0]        rad_tbl [NUM_NODES];
    bit                 seen    [NUM_NODES];
    int                 found_list [LIST_CAP];
    int                 found_cnt, emit_idx, open_idx, layer_stop, slot_pos, walk_hop;
    bit                 walking;
    int                 query_id;
    logic [5:0]         cfg_row_width = RW_RESET;
    logic [3:0]         cfg_hops      = HOPS_RESET;
    logic [15:0]        cfg_ratio     = RATIO_RESET;

    int                 pool [POOL_SZ];   // only these rows are ever written and walked
    t_cand              cand_q[$];        // candidates still owed by the DUT

    int   n_results, n_found, n_mismatch, n_items, n_starts;
    bit   gap_on, stall_on;
    int   hold_req;

    // Slot value as a neighbor, or -1 when empty
    function automatic int slot_nbr(int row, int s);
        logic signed [12:0] v;
        v = nbr_tbl[row*MAX_ROW + s];
        return (v < 0) ? -1 : int'(v);
    endfunction

    function automatic void record(int v);
        if (found_cnt < LIST_CAP) begin
            found_list[found_cnt] = v;
            found_cnt++;
        end
        emit_idx = found_cnt;
    endfunction

    // Next candidate in breadth-first order, pruning by density
    function automatic t_cand bfs_next();
        t_cand r;
        int rw, hops, u, v;
        longint unsigned lim;
        r = '0;
        rw = (cfg_row_width > MAX_ROW) ? MAX_ROW : int'(cfg_row_width);
        hops = (cfg_hops == 0) ? 1 : ((cfg_hops > MAX_HOPS) ? MAX_HOPS : int'(cfg_hops));
        while (walking) begin
            if (walk_hop == 1) begin
                while (slot_pos < rw) begin
                    v = slot_nbr(query_id, slot_pos);
                    slot_pos++;
                    if (v < 0) continue;
                    seen[v] = 1'b1;   // seeds are never tested against the marks
                    record(v);
                    r.found = 1'b1; r.node = v[11:0]; r.hop = 4'd1;
                    return r;
                end
            end else begin
                while (open_idx < layer_stop && open_idx < LIST_CAP) begin
                    u = found_list[open_idx];
                    lim = longint'(cfg_ratio) * longint'(rad_tbl[u]);
                    while (slot_pos < rw) begin
                        v = slot_nbr(u, slot_pos);
                        slot_pos++;
                        if (v < 0 || seen[v]) continue;
                        if ((longint'(rad_tbl[v]) << 16) < lim) continue;
                        seen[v] = 1'b1;
                        record(v);
                        r.found = 1'b1; r.node = v[11:0]; r.hop = walk_hop[3:0];
                        return r;
                    end
                    open_idx++;
                    slot_pos = 1;
                end
            end
            // layer done, step to the next hop
            open_idx = layer_stop;
            layer_stop = found_cnt;
            slot_pos = 1;
            walk_hop++;
            if (walk_hop > hops || open_idx >= layer_stop) walking = 1'b0;
        end
        return r;
    endfunction

    function automatic void apply_item(t_op op, logic [11:0] node, logic [4:0] slot,
                                       logic signed [12:0] nbr, logic [31:0] rad);
        t_cand nxt;
        case (op)
            OP_WR_NBR: nbr_tbl[node*MAX_ROW + slot] = nbr;
            OP_WR_RAD: rad_tbl[node] = rad;
            OP_START: begin
                foreach (seen[i]) seen[i] = 1'b0;
                found_cnt = 0; emit_idx = 0; open_idx = 0; layer_stop = 0;
                slot_pos = 1; walk_hop = 1; query_id = node; walking = 1'b1;
                n_starts++;
            end
            OP_NEXT: begin
                nxt = bfs_next();
                cand_q.insert(cand_q.size(), nxt);
            end
            default: ;
        endcase
    endfunction

    // ---------------------------------------------------------------
    // Driver tasks
    // ---------------------------------------------------------------
    task automatic send(t_op op, logic [11:0] node, logic [4:0] slot,
                        logic signed [12:0] nbr, logic [31:0] rad);
        if (gap_on && $urandom_range(99) < 10) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_opcode        <= op;
        i_node          <= node;
        i_slot          <= slot;
        i_neighbor_node <= nbr;
        i_radius_value  <= rad;
        do @(posedge i_clk); while (o_in_stall);
        apply_item(op, node, slot, nbr, rad);
        n_items++;
    endtask

    task automatic send_next();
        send(OP_NEXT, 12'($urandom), 5'($urandom), 13'($urandom), $urandom);
    endtask

    task automatic send_start(int node);
        send(OP_START, node[11:0], 5'($urandom), 13'($urandom), $urandom);
    endtask

    // Pause sending until every owed candidate has come back
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (cand_q.size() != 0) @(posedge i_clk);
        repeat (QUIET_CYC) @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic cfg_write(t_cfg_idx idx, logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_ROW_WIDTH:   cfg_row_width = data[5:0];
            CFG_HOP_COUNT:   cfg_hops      = data[3:0];
            CFG_PRUNE_RATIO: cfg_ratio     = data;
            default: ;
        endcase
    endtask

    task automatic set_cfg(logic [15:0] rw, logic [15:0] hops, logic [15:0] ratio);
        wait_drained();
        cfg_write(CFG_ROW_WIDTH, rw);
        cfg_write(CFG_HOP_COUNT, hops);
        cfg_write(CFG_PRUNE_RATIO, ratio);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [12:0] rand_nbr();
        if ($urandom_range(99) < 80) return 13'(pool[$urandom_range(POOL_SZ-1)]);
        return -13'($urandom_range(1, 4096));
    endfunction

    function automatic logic [31:0] rand_rad();
        case ($urandom_range(3))
            0:       return $urandom_range(1000, 1200);   // near ratio, pruning is close
            1:       return {$urandom_range(1) ? 32'hFFFF_FFFF : 32'h0};
            default: return $urandom;
        endcase
    endfunction

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    // No query open yet: next must report exhaustion
    task automatic test_next_without_query();
        send_next();
        send_next();
    endtask

    // Fill every slot and radius of the node pool, so no walk reads an unwritten entry
    task automatic test_load_graph();
        pool[0] = 0;
        pool[1] = NUM_NODES - 1;
        for (int i = 2; i < POOL_SZ; i++) pool[i] = $urandom_range(1, NUM_NODES - 2);
        foreach (pool[i]) begin
            for (int s = 0; s < MAX_ROW; s++)
                send(OP_WR_NBR, pool[i][11:0], s[4:0], rand_nbr(), $urandom);
            send(OP_WR_RAD, pool[i][11:0], 5'($urandom), 13'($urandom), rand_rad());
        end
    endtask

    // Hand-built row 0: duplicates, empties, self loop, extreme radii
    task automatic test_directed_row();
        send(OP_WR_NBR, 12'd0, 5'd1, 13'sd4095, 32'h0);
        send(OP_WR_NBR, 12'd0, 5'd2, 13'sd4095, 32'h0);            // duplicate seed
        send(OP_WR_NBR, 12'd0, 5'd3, -13'sd1, 32'h0);              // empty
        send(OP_WR_NBR, 12'd0, 5'd4, 13'sd0, 32'h0);               // query itself
        send(OP_WR_NBR, 12'd0, 5'd5, -13'sd4096, 32'h0);           // most negative
        send(OP_WR_NBR, 12'd0, 5'd31, 13'(pool[2]), 32'h0);
        send(OP_WR_RAD, 12'd4095, 5'd0, 13'sd0, 32'hFFFF_FFFF);
        send(OP_WR_RAD, 12'd0, 5'd0, 13'sd0, 32'h0);
        send_start(0);
        repeat (10) send_next();
        send_start(4095);                                          // restart mid-query
        repeat (4) send_next();
    endtask

    task automatic run_queries(int n_items_goal);
        int goal;
        goal = n_items + n_items_goal;
        while (n_items < goal) begin
            if ($urandom_range(99) < 85) begin
                send_start(pool[$urandom_range(POOL_SZ-1)]);
                repeat ($urandom_range(1, 12)) send_next();
            end else begin
                case ($urandom_range(2))
                    0: send(OP_WR_NBR, pool[$urandom_range(POOL_SZ-1)][11:0],
                            5'($urandom), rand_nbr(), $urandom);
                    1: send(OP_WR_RAD, pool[$urandom_range(POOL_SZ-1)][11:0],
                            5'($urandom), 13'($urandom), rand_rad());
                    default: send_next();
                endcase
            end
        end
    endtask

    // Receiver holds off long while nexts keep coming, so the input backs up
    task automatic test_backpressure();
        wait_drained();
        hold_req = 400;
        send_start(pool[$urandom_range(POOL_SZ-1)]);
        repeat (30) send_next();
        wait_drained();
    endtask

    // Walk through register settings, extremes included
    task automatic test_register_sweep();
        set_cfg(16'd32, 16'd8, 16'd0);            run_queries(60);
        set_cfg(16'd2, 16'd1, 16'hFFFF);          run_queries(60);
        set_cfg(16'd0, 16'd0, 16'd32768);         run_queries(30);  // no slots, hop 0 acts as 1
        set_cfg(16'd1, 16'd3, 16'd1);             run_queries(30);
        set_cfg(16'hFFFF, 16'hFFFF, 16'd55706);   run_queries(50);  // wide values saturate
        set_cfg(16'd7, 16'd4, 16'($urandom));     run_queries(50);
        set_cfg(16'd16, 16'd2, 16'd55706);
    endtask

    // ---------------------------------------------------------------
    // Result checker and watchdog
    // ---------------------------------------------------------------
    int quiet_cyc;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (i_cfg_valid && o_cfg_ready) ||
                (o_out_valid && !i_out_stall))
                quiet_cyc <= 0;
            else
                quiet_cyc <= quiet_cyc + 1;
            if (quiet_cyc >= WDOG_MAX) begin
                $display("%0t: watchdog, no transaction for %0d cycles", $time, quiet_cyc);
                $display("FAILED: results differ");
                $finish;
            end
            if (o_out_valid && !i_out_stall) begin
                t_cand want;
                n_results++;
                if (cand_q.size() == 0) begin
                    $display("%0t: unexpected result found=%0b node=%0d hop=%0d", $time,
                             o_found, o_candidate_node, o_hop_level);
                    n_mismatch++;
                end else begin
                    want = cand_q.pop_front();
                    if (want.found) n_found++;
                    if (o_found !== want.found) begin
                        $display("%0t: found exp %0b got %0b", $time, want.found, o_found);
                        n_mismatch++;
                    end
                    if (o_candidate_node !== want.node) begin
                        $display("%0t: candidate_node exp %0d got %0d", $time, want.node,
                                 o_candidate_node);
                        n_mismatch++;
                    end
                    if (o_hop_level !== want.hop) begin
                        $display("%0t: hop_level exp %0d got %0d", $time, want.hop,
                                 o_hop_level);
                        n_mismatch++;
                    end
                end
            end
        end else begin
            quiet_cyc <= 0;
        end
    end

    // Result-side stall: random idling plus requested long hold-offs
    int hold_cnt;
    always @(posedge i_clk) begin
        if (hold_req > 0) begin
            hold_cnt = hold_req;
            hold_req = 0;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= stall_on && ($urandom_range(99) < 10);
        end
    end

    // ---------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------
    initial begin
        foreach (seen[i]) seen[i] = 1'b0;
        walking = 1'b0; query_id = 0; walk_hop = 0; slot_pos = 1;
        found_cnt = 0; emit_idx = 0; open_idx = 0; layer_stop = 0;
        gap_on = 1'b1; stall_on = 1'b1; hold_req = 0; hold_cnt = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_next_without_query();
        test_load_graph();
        test_directed_row();
        // stretch with no idling on either side
        gap_on = 1'b0; stall_on = 1'b0;
        run_queries(80);
        gap_on = 1'b1; stall_on = 1'b1;
        run_queries(80);
        test_backpressure();
        test_register_sweep();
        run_queries(60);

        wait_drained();
        $display("Covered %0d transactions, %0d queries, %0d results (%0d candidates),",
                 n_items, n_starts, n_results, n_found);
        $display("register sweep with extremes, back-pressure hold and idle gaps.");
        if (n_mismatch == 0 && cand_q.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("%0d mismatches, %0d results missing", n_mismatch, cand_q.size());
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule
